// ===== src/anbp_pkg.sv =====
// anbp_pkg: shared types, constants and the nal type filter for the
// annex b length prefixer. No dependencies.
`default_nettype none

package anbp_pkg;

  // widths
  localparam int PositionBits = 24;
  localparam int QueueDepth   = 4;
  localparam int OffsetBits   = 24;
  localparam int SizeBits     = 25;
  localparam int InDataBits   = 8;
  localparam int OutDataBits  = 56;

  // h.264 nal unit types that get a length record
  localparam logic [4:0] NalSlice = 5'd1;
  localparam logic [4:0] NalIdr   = 5'd5;
  localparam logic [4:0] NalSei   = 5'd6;
  localparam logic [4:0] NalSps   = 5'd7;
  localparam logic [4:0] NalPps   = 5'd8;

  // low five header bits hold the h.264 nal type
  localparam logic [7:0] H264TypeMask = 8'h1f;

  // one queue entry: the records caused by one stream byte
  typedef struct packed {
    logic                  rec_valid;
    logic [OffsetBits-1:0] rec_offset;
    logic [SizeBits-1:0]   rec_size;
    logic                  fin_valid;
    logic [OffsetBits-1:0] fin_offset;
    logic [SizeBits-1:0]   fin_size;
  } anbp_entry_t;

  // front status seen by the top level
  typedef struct packed {
    logic open_valid;
    logic at_start;
  } anbp_front_stat_t;

  // does this header open a unit that gets a record
  function automatic logic type_qualifies(logic [7:0] hdr, logic hevc);
    logic [7:0] t;
    logic       q;
    t = hdr & H264TypeMask;
    case (t[4:0]) inside
      NalSlice, NalIdr, NalSei, NalSps, NalPps: q = 1'b1;
      default:                                  q = 1'b0;
    endcase
    return hevc | q;
  endfunction

endpackage

`default_nettype wire

// ===== src/anbp_front.sv =====
// anbp_front: start code scan, header classification and record arithmetic.
// Depends on anbp_pkg.
`default_nettype none

module anbp_front #(
  parameter int POSITION_BITS = anbp_pkg::PositionBits
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hevc_mode,
  input  wire logic                       fire,
  input  wire logic [7:0]                 stream_byte,
  input  wire logic                       end_of_stream,
  output logic                            push,
  output anbp_pkg::anbp_entry_t           entry,
  output anbp_pkg::anbp_front_stat_t      stat
);
  import anbp_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int WW = (P + 1 > SizeBits) ? P + 1 : SizeBits;

  logic [23:0]  hist_r, hist_nxt;
  logic         hdr_exp_r, hdr_exp_nxt;
  logic [P-1:0] pos_r, pos_nxt;
  logic [P-1:0] open_pos_r, open_pos_nxt;
  logic         open_valid_r, open_valid_nxt;

  logic         hit, rec_ok, fin_ok;
  logic [P:0]   idx_w, rec_end, rec_sz, total, open_w, fin_sz;
  logic [P-1:0] rec_off, fin_off;
  logic [WW-1:0] rec_sz_x, fin_sz_x, rec_off_x, fin_off_x;

  // header classification and record for the unit being closed
  always_comb begin
    hit     = hdr_exp_r && type_qualifies(stream_byte, hevc_mode);
    rec_ok  = hit && open_valid_r && (open_pos_r >= P'(4));
    idx_w   = {1'b0, pos_r};
    rec_end = {1'b0, open_pos_r} + (P+1)'(4);
    rec_sz  = (idx_w >= rec_end) ? idx_w - rec_end : '0;
    rec_off = open_pos_r - P'(4);
    open_pos_nxt   = hit ? pos_r : open_pos_r;
    open_valid_nxt = hit | open_valid_r;
  end

  // closing record at the end of the stream
  always_comb begin
    fin_ok  = end_of_stream && open_valid_nxt && (open_pos_nxt >= P'(4));
    total   = idx_w + (P+1)'(1);
    open_w  = {1'b0, open_pos_nxt};
    fin_sz  = (total >= open_w) ? total - open_w : '0;
    fin_off = open_pos_nxt - P'(4);
  end

  // fit to the output field widths
  always_comb begin
    rec_sz_x  = WW'(rec_sz);
    fin_sz_x  = WW'(fin_sz);
    rec_off_x = WW'(rec_off);
    fin_off_x = WW'(fin_off);
    entry.rec_valid  = rec_ok;
    entry.rec_offset = rec_off_x[OffsetBits-1:0];
    entry.rec_size   = rec_sz_x[SizeBits-1:0];
    entry.fin_valid  = fin_ok;
    entry.fin_offset = fin_off_x[OffsetBits-1:0];
    entry.fin_size   = fin_sz_x[SizeBits-1:0];
    push             = fire && (rec_ok || fin_ok);
  end

  // history and position advance
  always_comb begin
    hist_nxt    = {hist_r[15:0], stream_byte};
    hdr_exp_nxt = (hist_nxt == 24'h000001);
    pos_nxt     = (pos_r == '1) ? pos_r : pos_r + P'(1);
  end

  // stream state, cleared after the end byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      hdr_exp_r    <= 1'b0;
      pos_r        <= '0;
      open_pos_r   <= '0;
      open_valid_r <= 1'b0;
    end else if (fire) begin
      if (end_of_stream) begin
        hist_r       <= '0;
        hdr_exp_r    <= 1'b0;
        pos_r        <= '0;
        open_pos_r   <= '0;
        open_valid_r <= 1'b0;
      end else begin
        hist_r       <= hist_nxt;
        hdr_exp_r    <= hdr_exp_nxt;
        pos_r        <= pos_nxt;
        open_pos_r   <= open_pos_nxt;
        open_valid_r <= open_valid_nxt;
      end
    end
  end

  assign stat.open_valid = open_valid_r;
  assign stat.at_start   = (pos_r == '0) && (hist_r == '0) && !hdr_exp_r;

endmodule

`default_nettype wire

// ===== src/anbp_fifo.sv =====
// anbp_fifo: short register queue of record entries between front and back.
// Depends on anbp_pkg.
`default_nettype none

module anbp_fifo #(
  parameter int DEPTH = anbp_pkg::QueueDepth
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  anbp_pkg::anbp_entry_t      push_entry,
  input  wire logic                  pop,
  output anbp_pkg::anbp_entry_t      head,
  output logic                       empty,
  output logic                       full
);
  import anbp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  anbp_entry_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/anbp_back.sv =====
// anbp_back: splits each queue entry into one or two output transactions.
// Depends on anbp_pkg.
`default_nettype none

module anbp_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  anbp_pkg::anbp_entry_t                head,
  input  wire logic                            empty,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [anbp_pkg::OutDataBits-1:0]     out_tdata,
  output logic                                 out_tlast
);
  import anbp_pkg::*;

  logic                  rec_sent_r, rec_sent_nxt;
  logic                  show_rec, fire;
  logic [OffsetBits-1:0] offset;
  logic [SizeBits-1:0]   size;

  // pick the ordinary record first, then the closing one
  always_comb begin
    show_rec   = head.rec_valid && !rec_sent_r;
    offset     = show_rec ? head.rec_offset : head.fin_offset;
    size       = show_rec ? head.rec_size : head.fin_size;
    out_tvalid = !empty;
    out_tlast  = !show_rec;
    out_tdata  = {(OutDataBits - OffsetBits - SizeBits)'(0), size, offset};
    fire       = out_tvalid && out_tready;
    pop        = fire && (!show_rec || !head.fin_valid);
  end

  // remember that the first half of a double entry went out
  always_comb begin
    rec_sent_nxt = rec_sent_r;
    if (fire && show_rec && head.fin_valid) begin
      rec_sent_nxt = 1'b1;
    end else if (pop) begin
      rec_sent_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_sent_r <= 1'b0;
    end else begin
      rec_sent_r <= rec_sent_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/annexb_nal_length_prefixer.sv =====
// annexb_nal_length_prefixer: top level, joins front, record queue and back.
// Depends on anbp_pkg, anbp_front, anbp_fifo, anbp_back.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_tvalid/in_tready  | in_tdata: stream_byte; in_tlast: eos
//   out     | out_tvalid/out_tready| out_tdata: offset, size; out_tlast: final
//   cfg     | cfg_valid/cfg_ready  | cfg_data: hevc_mode
//
// One stream byte is taken per cycle while in_tready is high; its records are
// worked out in that cycle. Records leave one per cycle while out_tready is high,
// so a byte with two records holds the back for both; QUEUE_DEPTH entries absorb this.
// in_tready drops only while the queue is full; cfg_ready is always high.
// Reset is synchronous, active low: stream state clears and hevc_mode is 0.
`default_nettype none

module annexb_nal_length_prefixer #(
  parameter int POSITION_BITS = anbp_pkg::PositionBits,
  parameter int QUEUE_DEPTH   = anbp_pkg::QueueDepth
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [anbp_pkg::InDataBits-1:0]  in_tdata,   // [7:0] stream_byte
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [anbp_pkg::OutDataBits-1:0]      out_tdata,  // [23:0] prefix_offset,
                                                            // [48:24] unit_size, zero above
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_data
);
  import anbp_pkg::*;

  logic             hevc_mode_r;
  logic             in_fire, push, pop, empty, full;
  anbp_entry_t      entry, head;
  anbp_front_stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hevc_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hevc_mode_r <= cfg_data;
    end
  end

  anbp_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .hevc_mode     (hevc_mode_r),
    .fire          (in_fire),
    .stream_byte   (in_tdata),
    .end_of_stream (in_tlast),
    .push          (push),
    .entry         (entry),
    .stat          (stat)
  );

  anbp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  anbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // input only stalls behind pending records
  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending record");

  // end byte returns the scanner to a fresh stream
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (stat.at_start && !stat.open_valid))
    else $error("stream state not cleared after end byte");

  // an ordinary record with a closing one queued behind it is followed by it
  a_final_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast && head.fin_valid)
      |=> (out_tvalid && out_tlast))
    else $error("closing record lost after ordinary record");

endmodule

`default_nettype wire

// ===== tb/nal_record_board_pkg.sv =====
// nal_record_board_pkg: record predictor and checker for the annex b length
// prefixer testbench. Depends on anbp_pkg for widths and nal type codes.
`timescale 1ns / 1ps

package nal_record_board_pkg;

  import anbp_pkg::*;

  localparam int PadBits = OutDataBits - OffsetBits - SizeBits;

  // one length record as it leaves the block
  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [SizeBits-1:0]   size;
    logic                  fin;
  } nal_record_t;

  class nal_record_board;
    int unsigned errors;
    bit          hevc;
    logic [23:0] history;
    bit          hdr_expected;
    int unsigned pos;
    int unsigned open_hdr;
    bit          open_valid;
    nal_record_t pending_records[$];

    function new();
      errors = 0;
      hevc   = 1'b0;
      clear_stream();
    endfunction

    function void clear_stream();
      history      = '0;
      hdr_expected = 1'b0;
      pos          = 0;
      open_hdr     = 0;
      open_valid   = 1'b0;
    endfunction

    // h.264 keeps slices, idr, sei, sps and pps; hevc keeps everything
    function bit keeps_unit(logic [7:0] hdr);
      logic [7:0] t;
      t = hdr & H264TypeMask;
      if (hevc) return 1'b1;
      case (t[4:0])
        NalSlice, NalIdr, NalSei, NalSps, NalPps: return 1'b1;
        default:                                  return 1'b0;
      endcase
    endfunction

    function void push_record(int unsigned off, int unsigned sz, bit fin);
      nal_record_t r;
      r.offset = off[OffsetBits-1:0];
      r.size   = sz[SizeBits-1:0];
      r.fin    = fin;
      pending_records.push_back(r);
    endfunction

    // advance the stream by one accepted byte and queue the records it closes
    function void note_byte(logic [7:0] b, bit eos);
      int unsigned idx;
      int unsigned sz;
      int unsigned pos_max;
      pos_max = (32'd1 << PositionBits) - 1;
      idx     = pos;
      if (hdr_expected && keeps_unit(b)) begin
        // units opened in the first four bytes have no room for a prefix
        if (open_valid && open_hdr >= 4) begin
          sz = (idx >= open_hdr + 4) ? idx - open_hdr - 4 : 0;
          push_record(open_hdr - 4, sz, 1'b0);
        end
        open_hdr   = idx;
        open_valid = 1'b1;
      end
      history      = {history[15:0], b};
      hdr_expected = (history == 24'h000001);
      pos          = (idx < pos_max) ? idx + 1 : pos_max;
      if (eos) begin
        if (open_valid && open_hdr >= 4) begin
          sz = (idx + 1 >= open_hdr) ? idx + 1 - open_hdr : 0;
          push_record(open_hdr - 4, sz, 1'b1);
        end
        clear_stream();
      end
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // compare one record transaction with the oldest prediction
    task check_record(logic [OffsetBits-1:0] off, logic [SizeBits-1:0] sz, logic fin,
                      logic [PadBits-1:0] pad);
      nal_record_t want;
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record offset %0d size %0d final %0b",
                                  off, sz, fin));
        return;
      end
      want = pending_records.pop_front();
      if (off !== want.offset)
        report_mismatch($sformatf("offset %0d, want %0d", off, want.offset));
      if (sz !== want.size)
        report_mismatch($sformatf("size %0d at offset %0d, want %0d", sz, want.offset,
                                  want.size));
      if (fin !== want.fin)
        report_mismatch($sformatf("final flag %0b at offset %0d, want %0b", fin,
                                  want.offset, want.fin));
      if (pad !== '0)
        report_mismatch($sformatf("nonzero upper data bits %0h", pad));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// tb_top: drives annex b byte streams into annexb_nal_length_prefixer in both
// header modes and checks every length record. Depends on anbp_pkg, nal_record_board_pkg.
`timescale 1ns / 1ps

module tb_top;

  import anbp_pkg::*;
  import nal_record_board_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [InDataBits-1:0]  in_tdata;   // [7:0] stream_byte
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OutDataBits-1:0] out_tdata;  // [23:0] prefix_offset, [48:24] unit_size, zero above
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;

  nal_record_board board;
  logic [8:0]      stream_items[$];  // {end_of_stream, stream_byte}
  bit              long_hold_req;

  annexb_nal_length_prefixer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // all transactions seen in one place, so byte and record order cannot race
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        board.hevc = cfg_data;
      if (in_tvalid && in_tready)
        board.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        board.check_record(out_tdata[OffsetBits-1:0],
                           out_tdata[OffsetBits +: SizeBits], out_tlast,
                           out_tdata[OutDataBits-1:OffsetBits+SizeBits]);
    end
  end

  // record sink: changing stall patterns, plus a long hold-off on request
  initial begin : record_sink
    int hold_left;
    int pattern;
    int pattern_left;
    int tick;
    hold_left    = 0;
    pattern      = 0;
    pattern_left = 0;
    tick         = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        case (pattern)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void put_byte(logic [7:0] b);
    stream_items.push_back({1'b0, b});
  endfunction

  function automatic void mark_end();
    stream_items[stream_items.size() - 1][8] = 1'b1;
  endfunction

  function automatic void queue_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) put_byte(seq[i]);
    mark_end();
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 5) == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  // start code of three or four bytes, header, random payload
  function automatic void queue_unit(bit hevc, int max_payload);
    logic [7:0] hdr;
    if ($urandom_range(0, 1)) put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h01);
    if (hevc || $urandom_range(0, 3) == 0) begin
      hdr = 8'($urandom_range(0, 255));
    end else begin
      hdr[7:5] = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
        0:       hdr[4:0] = NalSlice;
        1:       hdr[4:0] = NalIdr;
        2:       hdr[4:0] = NalSei;
        3:       hdr[4:0] = NalSps;
        default: hdr[4:0] = NalPps;
      endcase
    end
    put_byte(hdr);
    repeat ($urandom_range(0, max_payload)) put_byte(payload_byte());
  endfunction

  // mostly well-formed streams, some with junk in front or a dangling start
  // code at the end, and some pure noise rich in zeros and ones
  function automatic void queue_stream(bit hevc, int max_payload);
    int kind;
    kind = $urandom_range(0, 7);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(0, 2))
          0:       put_byte(8'h00);
          1:       put_byte(8'h01);
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if (kind == 1) repeat ($urandom_range(1, 3)) put_byte(payload_byte());
      repeat ($urandom_range(1, 5)) queue_unit(hevc, max_payload);
      if (kind == 2) begin
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
      end
    end
    mark_end();
  endfunction

  // send every queued byte, in bursts with random gaps unless told not to
  task automatic send_stream_bytes(bit no_gaps);
    int         burst_left;
    int         gap;
    logic [8:0] item;
    burst_left = 0;
    while (stream_items.size() > 0) begin
      if (burst_left == 0) begin
        if (!no_gaps) begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            @(negedge clk);
            in_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      item = stream_items.pop_front();
      @(negedge clk);
      in_tvalid <= 1'b1;
      in_tdata  <= item[7:0];
      in_tlast  <= item[8];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait for all predicted records, then let any record-free bytes drain
  task automatic settle_records();
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_mode(bit hevc);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= hevc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(bit hevc, int n_bytes, int max_payload, bit no_gaps);
    while (stream_items.size() < n_bytes) queue_stream(hevc, max_payload);
    send_stream_bytes(no_gaps);
    settle_records();
  endtask

  initial begin
    board         = new();
    long_hold_req = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // h.264 at reset mode: header at the earliest usable offset, a skipped
    // type, end on a header (two records), end on a start code
    queue_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h09,
                  8'haa, 8'h00, 8'h00, 8'h01, 8'h68});
    queue_bytes('{8'h5a, 8'h00, 8'h00, 8'h01, 8'he5, 8'h00, 8'h00, 8'h01});
    send_stream_bytes(1'b0);
    settle_records();

    // hevc: zero header overlapping the next start code, start code at the
    // very beginning, lone byte stream
    write_mode(1'b1);
    queue_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h26, 8'hff});
    queue_bytes('{8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h42});
    queue_bytes('{8'h80});
    send_stream_bytes(1'b0);
    settle_records();

    write_mode(1'b0);
    random_phase(1'b0, 200, 10, 1'b0);
    write_mode(1'b1);
    random_phase(1'b1, 200, 10, 1'b0);
    write_mode(1'b0);
    random_phase(1'b0, 120, 4, 1'b0);

    // dense short units at full rate against a long sink hold-off
    write_mode(1'b1);
    long_hold_req = 1'b1;
    random_phase(1'b1, 100, 2, 1'b1);

    if (board.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
